// File: rtl/core/lc3_pkg.sv
// ----------------------------------------------------------------------------
// LC-3 core package
// Shared types, constants and helper functions for the LC-3 instruction core.
// ----------------------------------------------------------------------------
package lc3_pkg;

    localparam int MEM_WORDS_DEF = 65536;

    localparam logic [15:0] PC_RESET   = 16'h3000;
    localparam logic [15:0] REG_RESET  = 16'h1234;
    localparam logic [15:0] MEM_RESET  = 16'hDDDD;
    localparam logic [15:0] PSR_RESET  = 16'h0002;
    localparam logic [7:0]  TRAP_OUT   = 8'h67;
    localparam logic [7:0]  TRAP_PSR   = 8'h68;
    localparam logic [7:0]  TRAP_HALT  = 8'h25;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_SHOW   = 3'd1;
    localparam logic [2:0] ST_PSR    = 3'd2;
    localparam logic [2:0] ST_HALTED = 3'd3;
    localparam logic [2:0] ST_PRIV   = 3'd4;
    localparam logic [2:0] ST_UNDEF  = 3'd5;

    localparam logic [3:0] OP_BR   = 4'h0;
    localparam logic [3:0] OP_ADD  = 4'h1;
    localparam logic [3:0] OP_LD   = 4'h2;
    localparam logic [3:0] OP_ST   = 4'h3;
    localparam logic [3:0] OP_JSR  = 4'h4;
    localparam logic [3:0] OP_AND  = 4'h5;
    localparam logic [3:0] OP_LDR  = 4'h6;
    localparam logic [3:0] OP_STR  = 4'h7;
    localparam logic [3:0] OP_RTI  = 4'h8;
    localparam logic [3:0] OP_NOT  = 4'h9;
    localparam logic [3:0] OP_LDI  = 4'hA;
    localparam logic [3:0] OP_STI  = 4'hB;
    localparam logic [3:0] OP_JMP  = 4'hC;
    localparam logic [3:0] OP_RES  = 4'hD;
    localparam logic [3:0] OP_LEA  = 4'hE;
    localparam logic [3:0] OP_TRAP = 4'hF;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_EXEC,
        S_MEM1,
        S_MEM2,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_AND,
        ALU_NOT,
        ALU_PASS
    } t_alu_op;

    function automatic logic [15:0] sext5(input logic [15:0] v);
        return {{11{v[4]}}, v[4:0]};
    endfunction

    function automatic logic [15:0] sext6(input logic [15:0] v);
        return {{10{v[5]}}, v[5:0]};
    endfunction

    function automatic logic [15:0] sext9(input logic [15:0] v);
        return {{7{v[8]}}, v[8:0]};
    endfunction

    function automatic logic [15:0] sext11(input logic [15:0] v);
        return {{5{v[10]}}, v[10:0]};
    endfunction

    function automatic logic [15:0] flags_of(input logic keep, input logic [15:0] v);
        logic [2:0] nzp;
        if (v[15]) begin
            nzp = 3'b100;
        end else if (v == 16'h0000) begin
            nzp = 3'b010;
        end else begin
            nzp = 3'b001;
        end
        return {keep, 12'h000, nzp};
    endfunction

endpackage

// File: rtl/core/lc3_alu.sv
// ----------------------------------------------------------------------------
// LC-3 shared arithmetic unit
// One 16-bit add, and, not or pass unit used by every step of the sequencer.
// ----------------------------------------------------------------------------
module lc3_alu (
    input  lc3_pkg::t_alu_op i_op,
    input  logic [15:0]      i_a,
    input  logic [15:0]      i_b,
    output logic [15:0]      o_y
);

    always_comb begin
        case (i_op)
            lc3_pkg::ALU_ADD: o_y = i_a + i_b;
            lc3_pkg::ALU_AND: o_y = i_a & i_b;
            lc3_pkg::ALU_NOT: o_y = ~i_a;
            default:          o_y = i_a;
        endcase
    end

endmodule

// File: rtl/core/lc3_mem.sv
// ----------------------------------------------------------------------------
// LC-3 word memory
// Single-port word memory with registered read, address folding into the
// configured depth, and a clearing pass after reset.
// ----------------------------------------------------------------------------
module lc3_mem #(
    parameter int MEM_WORDS = lc3_pkg::MEM_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_addr,
    input  logic        i_we,
    input  logic [15:0] i_wdata,
    output logic [15:0] o_rdata,
    output logic        o_clearing
);

    localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

    logic [15:0]   r_mem [MEM_WORDS];
    logic [15:0]   r_rdata;
    logic [AW-1:0] r_clr;
    logic [AW-1:0] n_clr;
    logic          r_clearing;
    logic          n_clearing;
    logic [AW-1:0] idx;
    logic [31:0]   base;
    logic [AW-1:0] wr_idx;
    logic [15:0]   wr_data;
    logic          wr_en;

    always_comb begin
        base = 32'd0;
        for (int k = 1; k < 16; k++) begin
            if ({16'h0000, i_addr} >= 32'(k * MEM_WORDS)) begin
                base = 32'(k * MEM_WORDS);
            end
        end
        idx = AW'({16'h0000, i_addr} - base);
    end

    always_comb begin
        n_clr      = r_clr;
        n_clearing = r_clearing;
        if (r_clearing) begin
            n_clr = r_clr + AW'(1);
            if (r_clr == AW'(MEM_WORDS - 1)) begin
                n_clearing = 1'b0;
            end
        end
        wr_en   = r_clearing | i_we;
        wr_idx  = r_clearing ? r_clr : idx;
        wr_data = r_clearing ? lc3_pkg::MEM_RESET : i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= '0;
            r_clearing <= 1'b1;
        end else begin
            r_clr      <= n_clr;
            r_clearing <= n_clearing;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= wr_data;
        end
        r_rdata <= r_mem[idx];
    end

    assign o_rdata    = r_rdata;
    assign o_clearing = r_clearing;

endmodule

// File: rtl/core/lc3_instruction_core.sv
// A load, or a step on a stopped core, shows its result word in the cycle after
// it is accepted. Other steps pass the fetch, execute and done states; ld, ldr,
// ldi, sti, unfaulted rti and vectored traps add a memory state, and ldi and rti
// a second one; busy drops the next cycle. One command is in flight at a time;
// the single memory port sets the pace. Reset is synchronous; afterwards memory
// is swept with busy high. Results are shown for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
// LC-3 instruction core
// Sequencer, register file and status state of a 16-bit LC-3 core with
// its own word memory, sharing one arithmetic unit across all steps.
// ----------------------------------------------------------------------------
module lc3_instruction_core #(
    parameter int MEM_WORDS = lc3_pkg::MEM_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_command,
    input  logic [15:0] i_address,
    input  logic [15:0] i_load_data,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [15:0] o_report_value,
    output logic [15:0] o_next_pc
);

    lc3_pkg::t_state  r_state;
    lc3_pkg::t_state  n_state;
    lc3_pkg::t_alu_op alu_op;

    logic [15:0] r_rf [8];
    logic [15:0] r_pc, n_pc;
    logic [15:0] r_psr, n_psr;
    logic        r_stopped, n_stopped;
    logic [15:0] r_ir, n_ir;
    logic [15:0] r_opa, r_opb;
    logic [2:0]  r_status, n_status;
    logic [15:0] r_report, n_report;

    logic [15:0] alu_a, alu_b, alu_y;
    logic [15:0] mem_addr, mem_wdata, mem_rdata;
    logic        mem_we, mem_clearing;
    logic        rf_we;
    logic [2:0]  rf_waddr, rf_ra, rf_rb;
    logic [15:0] rf_wdata;
    logic [3:0]  opc;
    logic        trap_vec;
    logic        accept;

    assign opc      = r_ir[15:12];
    assign trap_vec = (r_ir[7:0] != lc3_pkg::TRAP_OUT) && (r_ir[7:0] != lc3_pkg::TRAP_PSR)
                      && (r_ir[7:0] != lc3_pkg::TRAP_HALT);
    assign accept   = start && (r_state == lc3_pkg::S_IDLE);

    lc3_alu u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_y  (alu_y)
    );

    lc3_mem #(
        .MEM_WORDS (MEM_WORDS)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_addr     (mem_addr),
        .i_we       (mem_we),
        .i_wdata    (mem_wdata),
        .o_rdata    (mem_rdata),
        .o_clearing (mem_clearing)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lc3_pkg::S_CLEAR: begin
                if (!mem_clearing) begin
                    n_state = lc3_pkg::S_IDLE;
                end
            end
            lc3_pkg::S_IDLE: begin
                if (start) begin
                    n_state = (i_command && !r_stopped) ? lc3_pkg::S_FETCH : lc3_pkg::S_DONE;
                end
            end
            lc3_pkg::S_FETCH: n_state = lc3_pkg::S_EXEC;
            lc3_pkg::S_EXEC: begin
                n_state = lc3_pkg::S_DONE;
                unique case (opc) inside
                    lc3_pkg::OP_LD, lc3_pkg::OP_LDR, lc3_pkg::OP_LDI,
                    lc3_pkg::OP_STI: n_state = lc3_pkg::S_MEM1;
                    lc3_pkg::OP_RTI: begin
                        if (!r_psr[15]) begin
                            n_state = lc3_pkg::S_MEM1;
                        end
                    end
                    lc3_pkg::OP_TRAP: begin
                        if (trap_vec) begin
                            n_state = lc3_pkg::S_MEM1;
                        end
                    end
                    default: n_state = lc3_pkg::S_DONE;
                endcase
            end
            lc3_pkg::S_MEM1: begin
                n_state = (opc == lc3_pkg::OP_LDI || opc == lc3_pkg::OP_RTI)
                          ? lc3_pkg::S_MEM2 : lc3_pkg::S_DONE;
            end
            lc3_pkg::S_MEM2: n_state = lc3_pkg::S_DONE;
            lc3_pkg::S_DONE: n_state = lc3_pkg::S_IDLE;
            default:         n_state = lc3_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_pc      = r_pc;
        n_psr     = r_psr;
        n_stopped = r_stopped;
        n_ir      = r_ir;
        n_status  = r_status;
        n_report  = r_report;
        alu_op    = lc3_pkg::ALU_ADD;
        alu_a     = r_pc;
        alu_b     = lc3_pkg::sext9(r_ir);
        mem_addr  = r_pc;
        mem_we    = 1'b0;
        mem_wdata = r_opb;
        rf_we     = 1'b0;
        rf_waddr  = r_ir[11:9];
        rf_wdata  = alu_y;
        rf_ra     = mem_rdata[8:6];
        rf_rb     = (mem_rdata[15:12] == lc3_pkg::OP_ST || mem_rdata[15:12] == lc3_pkg::OP_STR
                     || mem_rdata[15:12] == lc3_pkg::OP_STI) ? mem_rdata[11:9] : mem_rdata[2:0];
        unique case (r_state)
            lc3_pkg::S_IDLE: begin
                mem_addr  = i_command ? r_pc : i_address;
                mem_wdata = i_load_data;
                mem_we    = accept && !i_command;
                n_report  = 16'h0000;
                n_status  = (i_command && r_stopped) ? lc3_pkg::ST_HALTED : lc3_pkg::ST_OK;
            end
            lc3_pkg::S_FETCH: begin
                n_ir  = mem_rdata;
                alu_b = 16'h0001;
                n_pc  = alu_y;
            end
            lc3_pkg::S_EXEC: begin
                n_status = lc3_pkg::ST_OK;
                n_report = 16'h0000;
                unique case (opc) inside
                    lc3_pkg::OP_BR: begin
                        if ((r_psr[2:0] & r_ir[11:9]) != 3'b000) begin
                            n_pc = alu_y;
                        end
                    end
                    lc3_pkg::OP_ADD, lc3_pkg::OP_AND: begin
                        alu_op = (opc == lc3_pkg::OP_ADD) ? lc3_pkg::ALU_ADD : lc3_pkg::ALU_AND;
                        alu_a  = r_opa;
                        alu_b  = r_ir[5] ? lc3_pkg::sext5(r_ir) : r_opb;
                        rf_we  = 1'b1;
                        n_psr  = lc3_pkg::flags_of(r_psr[15], alu_y);
                    end
                    lc3_pkg::OP_NOT: begin
                        alu_op = lc3_pkg::ALU_NOT;
                        alu_a  = r_opa;
                        rf_we  = 1'b1;
                        n_psr  = lc3_pkg::flags_of(r_psr[15], alu_y);
                    end
                    lc3_pkg::OP_LEA: begin
                        rf_we = 1'b1;
                        n_psr = lc3_pkg::flags_of(r_psr[15], alu_y);
                    end
                    lc3_pkg::OP_LD, lc3_pkg::OP_LDI, lc3_pkg::OP_STI: begin
                        mem_addr = alu_y;
                    end
                    lc3_pkg::OP_ST: begin
                        mem_addr = alu_y;
                        mem_we   = 1'b1;
                    end
                    lc3_pkg::OP_LDR: begin
                        alu_a    = r_opa;
                        alu_b    = lc3_pkg::sext6(r_ir);
                        mem_addr = alu_y;
                    end
                    lc3_pkg::OP_STR: begin
                        alu_a    = r_opa;
                        alu_b    = lc3_pkg::sext6(r_ir);
                        mem_addr = alu_y;
                        mem_we   = 1'b1;
                    end
                    lc3_pkg::OP_JSR: begin
                        alu_b    = lc3_pkg::sext11(r_ir);
                        rf_we    = 1'b1;
                        rf_waddr = 3'd7;
                        rf_wdata = r_pc;
                        n_pc     = r_ir[11] ? alu_y : r_opa;
                    end
                    lc3_pkg::OP_JMP: n_pc = r_opa;
                    lc3_pkg::OP_RTI: begin
                        mem_addr = r_rf[6];
                        if (r_psr[15]) begin
                            n_status  = lc3_pkg::ST_PRIV;
                            n_stopped = 1'b1;
                        end
                    end
                    lc3_pkg::OP_RES: begin
                        n_status  = lc3_pkg::ST_UNDEF;
                        n_stopped = 1'b1;
                    end
                    default: begin
                        mem_addr = {8'h00, r_ir[7:0]};
                        if (r_ir[7:0] == lc3_pkg::TRAP_OUT) begin
                            n_status = lc3_pkg::ST_SHOW;
                            n_report = r_rf[0];
                        end else if (r_ir[7:0] == lc3_pkg::TRAP_PSR) begin
                            n_status = lc3_pkg::ST_PSR;
                            n_report = r_psr;
                        end else if (r_ir[7:0] == lc3_pkg::TRAP_HALT) begin
                            n_status  = lc3_pkg::ST_HALTED;
                            n_stopped = 1'b1;
                        end else begin
                            rf_we    = 1'b1;
                            rf_waddr = 3'd7;
                            rf_wdata = r_pc;
                        end
                    end
                endcase
            end
            lc3_pkg::S_MEM1: begin
                alu_a = r_rf[6];
                alu_b = 16'h0001;
                unique case (opc) inside
                    lc3_pkg::OP_LD, lc3_pkg::OP_LDR: begin
                        rf_we    = 1'b1;
                        rf_wdata = mem_rdata;
                        n_psr    = lc3_pkg::flags_of(r_psr[15], mem_rdata);
                    end
                    lc3_pkg::OP_LDI: mem_addr = mem_rdata;
                    lc3_pkg::OP_STI: begin
                        mem_addr = mem_rdata;
                        mem_we   = 1'b1;
                    end
                    lc3_pkg::OP_RTI: begin
                        n_pc     = mem_rdata;
                        mem_addr = alu_y;
                        rf_we    = 1'b1;
                        rf_waddr = 3'd6;
                    end
                    default: n_pc = mem_rdata;
                endcase
            end
            lc3_pkg::S_MEM2: begin
                alu_a = r_rf[6];
                alu_b = 16'h0001;
                if (opc == lc3_pkg::OP_RTI) begin
                    n_psr    = mem_rdata;
                    rf_we    = 1'b1;
                    rf_waddr = 3'd6;
                end else begin
                    rf_we    = 1'b1;
                    rf_wdata = mem_rdata;
                    n_psr    = lc3_pkg::flags_of(r_psr[15], mem_rdata);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lc3_pkg::S_CLEAR;
            r_stopped <= 1'b0;
            r_pc      <= lc3_pkg::PC_RESET;
            r_psr     <= lc3_pkg::PSR_RESET;
            for (int i = 0; i < 8; i++) begin
                r_rf[i] <= lc3_pkg::REG_RESET;
            end
        end else begin
            r_state   <= n_state;
            r_stopped <= n_stopped;
            r_pc      <= n_pc;
            r_psr     <= n_psr;
            if (rf_we) begin
                r_rf[rf_waddr] <= rf_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ir     <= n_ir;
        r_status <= n_status;
        r_report <= n_report;
        r_opa    <= r_rf[rf_ra];
        r_opb    <= r_rf[rf_rb];
    end

    assign busy           = (r_state != lc3_pkg::S_IDLE);
    assign o_done         = (r_state == lc3_pkg::S_DONE);
    assign o_status       = r_status;
    assign o_report_value = r_report;
    assign o_next_pc      = r_pc;

endmodule

// File: rtl/core/lc3_checker.sv
// ----------------------------------------------------------------------------
// LC-3 core port checker
// Checks the command and result behavior seen on the core's ports.
// ----------------------------------------------------------------------------
module lc3_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [2:0]  o_status,
    input logic [15:0] o_report_value
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("Core did not go busy after taking a word.");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done && !busy)
        else $error("Result strobe lasted more than one cycle.");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("Result shown while the core was idle.");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status <= lc3_pkg::ST_UNDEF))
        else $error("Result status out of range.");

    a_report_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status != lc3_pkg::ST_SHOW && o_status != lc3_pkg::ST_PSR
        |-> o_report_value == 16'h0000)
        else $error("Report value not zero for a plain result.");

endmodule

bind lc3_instruction_core lc3_checker u_lc3_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_done         (o_done),
    .o_status       (o_status),
    .o_report_value (o_report_value)
);

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LC-3 instruction core testbench
// Drives load and step commands through the start/busy handshake, mirrors
// the core's memory, registers and status in a scoreboard, and checks every
// result word against the mirrored outcome.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int N_RANDOM = 1070;
    localparam bit CMD_LOAD = 1'b0;
    localparam bit CMD_STEP = 1'b1;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] report;
        logic [15:0] pc;
    } t_result;

    class core_mirror;
        logic [15:0] mem [int];
        logic [15:0] regs [8];
        logic [15:0] pc;
        logic [15:0] psr;
        bit          stopped;
        t_result     expected_words [$];
        int          errors;

        function new();
            foreach (regs[i]) regs[i] = lc3_pkg::REG_RESET;
            pc = lc3_pkg::PC_RESET;
            psr = lc3_pkg::PSR_RESET;
            stopped = 0;
            errors = 0;
        endfunction

        function logic [15:0] rd(logic [15:0] a);
            return mem.exists(a) ? mem[a] : lc3_pkg::MEM_RESET;
        endfunction

        function logic [15:0] sx(logic [15:0] v, int n);
            logic signed [15:0] t;
            t = v << (16 - n);
            return t >>> (16 - n);
        endfunction

        function void set_nzp(logic [15:0] v);
            psr = {psr[15], 15'h0};
            if (v[15]) psr[2] = 1'b1;
            else if (v == 16'h0) psr[1] = 1'b1;
            else psr[0] = 1'b1;
        endfunction

        function void note_command(bit cmd, logic [15:0] addr, logic [15:0] data);
            t_result     r;
            logic [15:0] inst, off9, v;
            logic [2:0]  dr, s1, s2;
            r.status = lc3_pkg::ST_OK;
            r.report = 16'h0;
            if (cmd == CMD_LOAD) begin
                mem[addr] = data;
            end else if (stopped) begin
                r.status = lc3_pkg::ST_HALTED;
            end else begin
                inst = rd(pc);
                dr = inst[11:9];
                s1 = inst[8:6];
                s2 = inst[2:0];
                pc = pc + 16'd1;
                off9 = pc + sx(inst, 9);
                v = inst[5] ? sx(inst, 5) : regs[s2];
                case (inst[15:12])
                    lc3_pkg::OP_BR: if ((psr[2:0] & inst[11:9]) != 3'b0) pc = off9;
                    lc3_pkg::OP_ADD: begin
                        regs[dr] = regs[s1] + v;
                        set_nzp(regs[dr]);
                    end
                    lc3_pkg::OP_AND: begin
                        regs[dr] = regs[s1] & v;
                        set_nzp(regs[dr]);
                    end
                    lc3_pkg::OP_NOT: begin
                        regs[dr] = ~regs[s1];
                        set_nzp(regs[dr]);
                    end
                    lc3_pkg::OP_LD: begin
                        regs[dr] = rd(off9);
                        set_nzp(regs[dr]);
                    end
                    lc3_pkg::OP_LDI: begin
                        regs[dr] = rd(rd(off9));
                        set_nzp(regs[dr]);
                    end
                    lc3_pkg::OP_LDR: begin
                        regs[dr] = rd(regs[s1] + sx(inst, 6));
                        set_nzp(regs[dr]);
                    end
                    lc3_pkg::OP_LEA: begin
                        regs[dr] = off9;
                        set_nzp(regs[dr]);
                    end
                    lc3_pkg::OP_ST: mem[off9] = regs[dr];
                    lc3_pkg::OP_STI: mem[rd(off9)] = regs[dr];
                    lc3_pkg::OP_STR: mem[regs[s1] + sx(inst, 6)] = regs[dr];
                    lc3_pkg::OP_JSR: begin
                        v = regs[s1];
                        regs[7] = pc;
                        pc = inst[11] ? pc + sx(inst, 11) : v;
                    end
                    lc3_pkg::OP_JMP: pc = regs[s1];
                    lc3_pkg::OP_RTI: begin
                        if (psr[15]) begin
                            r.status = lc3_pkg::ST_PRIV;
                            stopped = 1;
                        end else begin
                            pc = rd(regs[6]);
                            regs[6] = regs[6] + 16'd1;
                            psr = rd(regs[6]);
                            regs[6] = regs[6] + 16'd1;
                        end
                    end
                    lc3_pkg::OP_RES: begin
                        r.status = lc3_pkg::ST_UNDEF;
                        stopped = 1;
                    end
                    default: begin
                        if (inst[7:0] == lc3_pkg::TRAP_OUT) begin
                            r.status = lc3_pkg::ST_SHOW;
                            r.report = regs[0];
                        end else if (inst[7:0] == lc3_pkg::TRAP_PSR) begin
                            r.status = lc3_pkg::ST_PSR;
                            r.report = psr;
                        end else if (inst[7:0] == lc3_pkg::TRAP_HALT) begin
                            r.status = lc3_pkg::ST_HALTED;
                            stopped = 1;
                        end else begin
                            regs[7] = pc;
                            pc = rd({8'h0, inst[7:0]});
                        end
                    end
                endcase
            end
            r.pc = pc;
            expected_words.push_back(r);
        endfunction

        function void check_word(logic [2:0] st, logic [15:0] rep, logic [15:0] npc);
            t_result e;
            if (expected_words.size() == 0) begin
                errors++;
                if (errors <= 10) $display("Unexpected result word: status %0d", st);
                return;
            end
            e = expected_words.pop_front();
            if (st !== e.status || rep !== e.report || npc !== e.pc) begin
                errors++;
                if (errors <= 10)
                    $display("Mismatch: status %0d/%0d report %h/%h next_pc %h/%h (exp/act)",
                             e.status, st, e.report, rep, e.pc, npc);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_command = 1'b0;
    logic [15:0] i_address = 16'h0;
    logic [15:0] i_load_data = 16'h0;
    logic        o_done;
    logic [2:0]  o_status;
    logic [15:0] o_report_value;
    logic [15:0] o_next_pc;

    core_mirror sb = new();
    int         idle_pct = 0;
    int         cycles = 0;

    lc3_instruction_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_command(i_command), .i_address(i_address), .i_load_data(i_load_data),
        .o_done(o_done), .o_status(o_status), .o_report_value(o_report_value),
        .o_next_pc(o_next_pc)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_word(o_status, o_report_value, o_next_pc);
    end

    task automatic issue(bit cmd, logic [15:0] addr, logic [15:0] data);
        int gap;
        start <= 1'b1;
        i_command <= cmd;
        i_address <= addr;
        i_load_data <= data;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_command(cmd, addr, data);
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic run_word(logic [15:0] inst);
        issue(CMD_LOAD, sb.pc, inst);
        issue(CMD_STEP, 16'($urandom), 16'($urandom));
    endtask

    function automatic logic [15:0] random_inst();
        logic [15:0] w;
        w = 16'($urandom);
        while (w[15:12] == lc3_pkg::OP_RES || (w[15:12] == lc3_pkg::OP_RTI && sb.psr[15]))
            w[15:12] = 4'($urandom_range(15));
        if (w[15:12] == lc3_pkg::OP_TRAP) begin
            case ($urandom_range(3))
                0: w[7:0] = lc3_pkg::TRAP_OUT;
                1: w[7:0] = lc3_pkg::TRAP_PSR;
                default: if (w[7:0] == lc3_pkg::TRAP_HALT) w[7:0] = lc3_pkg::TRAP_OUT;
            endcase
        end
        return w;
    endfunction

    initial begin
        logic [15:0] w;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        issue(CMD_LOAD, 16'h0000, 16'hFFFF);
        issue(CMD_LOAD, 16'hFFFF, 16'h0000);
        issue(CMD_LOAD, 16'h0040, 16'h4000);
        run_word({lc3_pkg::OP_TRAP, 4'h0, lc3_pkg::TRAP_PSR});
        run_word({lc3_pkg::OP_ADD, 3'd1, 3'd1, 1'b1, 5'h10});
        run_word({lc3_pkg::OP_AND, 3'd2, 3'd1, 1'b0, 2'b0, 3'd0});
        run_word({lc3_pkg::OP_NOT, 3'd3, 3'd2, 6'h3F});
        run_word({lc3_pkg::OP_LEA, 3'd4, 9'h100});
        run_word({lc3_pkg::OP_ST, 3'd3, 9'h0FF});
        run_word({lc3_pkg::OP_LD, 3'd5, 9'h1FF});
        run_word({lc3_pkg::OP_LDI, 3'd6, 9'h002});
        run_word({lc3_pkg::OP_STR, 3'd1, 3'd6, 6'h20});
        run_word({lc3_pkg::OP_LDR, 3'd0, 3'd6, 6'h1F});
        run_word({lc3_pkg::OP_STI, 3'd2, 9'h010});
        run_word({lc3_pkg::OP_BR, 3'b111, 9'h1FF});
        run_word({lc3_pkg::OP_TRAP, 4'h0, 8'h40});
        run_word({lc3_pkg::OP_JSR, 1'b1, 11'h400});
        run_word({lc3_pkg::OP_JSR, 1'b0, 2'b0, 3'd1, 6'h0});
        run_word({lc3_pkg::OP_JMP, 3'd0, 3'd7, 6'h0});
        run_word({lc3_pkg::OP_TRAP, 4'h0, lc3_pkg::TRAP_OUT});
        issue(CMD_LOAD, sb.regs[6], 16'h5000);
        issue(CMD_LOAD, sb.regs[6] + 16'd1, 16'h0004);
        run_word({lc3_pkg::OP_RTI, 12'h0});

        for (int n = 0; n < N_RANDOM; n++) begin
            idle_pct = (n < N_RANDOM / 4) ? 0 : (n < N_RANDOM / 2) ? 66 :
                       (n < 3 * N_RANDOM / 4) ? 0 : 32;
            if (n == N_RANDOM / 2) begin
                start <= 1'b0;
                while (sb.expected_words.size() != 0) @(posedge i_clk);
                repeat (6) @(posedge i_clk);
            end
            w = sb.rd(sb.pc);
            if ($urandom_range(3) == 0) begin
                issue(CMD_LOAD, 16'($urandom), 16'($urandom));
            end else if ($urandom_range(4) == 0 && w[15:12] != lc3_pkg::OP_RES &&
                         !(w[15:12] == lc3_pkg::OP_RTI && sb.psr[15]) &&
                         !(w[15:12] == lc3_pkg::OP_TRAP && w[7:0] == lc3_pkg::TRAP_HALT)) begin
                issue(CMD_STEP, 16'($urandom), 16'($urandom));
            end else begin
                if ($urandom_range(5) == 0) issue(CMD_LOAD, sb.regs[6], 16'($urandom));
                run_word(random_inst());
            end
        end

        case ($urandom_range(2))
            0: run_word({lc3_pkg::OP_TRAP, 4'h0, lc3_pkg::TRAP_HALT});
            1: run_word({lc3_pkg::OP_RES, 12'h0});
            default: begin
                if (!sb.psr[15]) begin
                    issue(CMD_LOAD, sb.regs[6], 16'h3100);
                    issue(CMD_LOAD, sb.regs[6] + 16'd1, 16'h8001);
                    run_word({lc3_pkg::OP_RTI, 12'h0});
                end
                run_word({lc3_pkg::OP_RTI, 12'h0});
            end
        endcase
        run_word({lc3_pkg::OP_ADD, 3'd0, 3'd0, 1'b1, 5'h01});
        issue(CMD_STEP, 16'h0, 16'h0);
        start <= 1'b0;

        while (sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_words.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// File: files.f
rtl/core/lc3_pkg.sv
rtl/core/lc3_alu.sv
rtl/core/lc3_mem.sv
rtl/core/lc3_instruction_core.sv
rtl/core/lc3_checker.sv
sim/tb_top.sv
